>>> design/delimited_frame_receiver_assert.svh
// assertion macros used by the frame receiver top level
`ifndef DELIMITED_FRAME_RECEIVER_ASSERT_SVH
`define DELIMITED_FRAME_RECEIVER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define DFR_ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define DFR_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/dfr_pkg.sv
// shared types and constants of the frame receiver
package dfr_pkg;

    localparam int BYTE_W      = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int MARKER_TAIL = 2;

    localparam logic [CFG_IDX_W-1:0] REG_FLAG      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_ONE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_TWO = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_END_ONE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_END_TWO   = 3'd4;

    localparam logic [BYTE_W-1:0] FLAG_RST      = 8'd0;
    localparam logic [BYTE_W-1:0] START_ONE_RST = 8'd1;
    localparam logic [BYTE_W-1:0] START_TWO_RST = 8'd2;
    localparam logic [BYTE_W-1:0] END_ONE_RST   = 8'd3;
    localparam logic [BYTE_W-1:0] END_TWO_RST   = 8'd4;

    typedef struct packed {
        logic [BYTE_W-1:0] flag_byte;
        logic [BYTE_W-1:0] start_one_byte;
        logic [BYTE_W-1:0] start_two_byte;
        logic [BYTE_W-1:0] end_one_byte;
        logic [BYTE_W-1:0] end_two_byte;
    } cfg_t;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_FLAG  = 4'b0010,
        PH_START = 4'b0100,
        PH_END   = 4'b1000
    } phase_t;

    typedef enum logic [3:0] {
        RD_ACCEPT = 4'b0001,
        RD_ISSUE  = 4'b0010,
        RD_LOAD   = 4'b0100,
        RD_EMPTY  = 4'b1000
    } rd_state_t;

    // per-byte decision from the marker tracker
    typedef struct packed {
        logic store;
        logic emit;
    } step_t;

endpackage

>>> design/dfr_ram.sv
// generic single-write, single-read ram with registered read data
module dfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/dfr_marker.sv
// marker tracker: phase, open flag and fill index
module dfr_marker #(
    parameter int STORE_DEPTH = 64,
    localparam int IDX_W = $clog2(STORE_DEPTH)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  dfr_pkg::cfg_t               cfg,
    input  logic [dfr_pkg::BYTE_W-1:0]  rx_byte,
    input  logic                        take,
    output dfr_pkg::step_t              step,
    output logic [IDX_W-1:0]            store_addr,
    output logic [IDX_W-1:0]            emit_len
);
    import dfr_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STORE_DEPTH - 1);
    localparam logic [IDX_W-1:0] TAIL     = IDX_W'(MARKER_TAIL);

    phase_t           phase_reg, phase_next;
    logic             open_reg, open_next;
    logic [IDX_W-1:0] fill_reg, fill_next;
    logic             keep;
    logic             close;
    logic [IDX_W-1:0] base;

    always_comb
    begin
        phase_next = phase_reg;
        open_next  = open_reg;
        fill_next  = fill_reg;
        keep       = 1'b1;
        close      = 1'b0;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (rx_byte == cfg.flag_byte)
                begin
                    phase_next = PH_FLAG;
                end
            end
            PH_FLAG:
            begin
                priority if (rx_byte == cfg.start_one_byte)
                begin
                    phase_next = PH_START;
                end
                else if (rx_byte == cfg.end_one_byte)
                begin
                    phase_next = PH_END;
                end
                else if (rx_byte == cfg.flag_byte)
                begin
                    phase_next = PH_FLAG;
                end
                else
                begin
                    phase_next = PH_IDLE;
                end
            end
            PH_START:
            begin
                phase_next = PH_IDLE;
                if (rx_byte == cfg.start_two_byte)
                begin
                    open_next = 1'b1;
                    keep      = 1'b0;
                    fill_next = '0;
                end
            end
            PH_END:
            begin
                phase_next = PH_IDLE;
                if (rx_byte == cfg.end_two_byte)
                begin
                    close = 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        // end marker restarts the store at entry zero
        base = close ? '0 : fill_reg;
        if (close)
        begin
            open_next = 1'b0;
        end
        if (keep)
        begin
            fill_next = base + 1'b1;
            if (base == LAST_IDX)
            begin
                fill_next  = '0;
                open_next  = 1'b0;
                phase_next = PH_IDLE;
            end
        end
    end

    // payload excludes the stored flag and end-one bytes
    assign emit_len   = (fill_reg >= TAIL) ? (fill_reg - TAIL) : '0;
    assign store_addr = base;
    assign step.emit  = take && close && open_reg;
    assign step.store = take && keep && !(close && open_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            open_reg  <= 1'b0;
            fill_reg  <= '0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            open_reg  <= open_next;
            fill_reg  <= fill_next;
        end
    end

endmodule

>>> design/dfr_readout.sv
// frame readout sequencer and result register
module dfr_readout #(
    parameter int STORE_DEPTH = 64,
    localparam int IDX_W = $clog2(STORE_DEPTH)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  dfr_pkg::step_t              step,
    input  logic [IDX_W-1:0]            emit_len,
    input  logic [dfr_pkg::BYTE_W-1:0]  rx_byte,
    output logic                        accepting,
    output logic                        rd_en,
    output logic [IDX_W-1:0]            rd_addr,
    input  logic [dfr_pkg::BYTE_W-1:0]  rd_data,
    output logic                        wb_en,
    output logic [dfr_pkg::BYTE_W-1:0]  wb_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [dfr_pkg::BYTE_W-1:0]  payload_byte,
    output logic                        last_of_frame,
    output logic                        frame_empty
);
    import dfr_pkg::*;

    rd_state_t         state_reg, state_next;
    logic [IDX_W-1:0]  len_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [BYTE_W-1:0] pend_reg;
    logic              valid_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic              last_reg;
    logic              empty_reg;
    logic              out_free;
    logic              is_last;
    logic              load;

    assign out_free = !valid_reg || out_ready;
    assign is_last  = (idx_reg + 1'b1) == len_reg;

    always_comb
    begin
        state_next = state_reg;
        rd_en      = 1'b0;
        wb_en      = 1'b0;
        load       = 1'b0;
        unique case (state_reg)
            RD_ACCEPT:
            begin
                if (step.emit)
                begin
                    state_next = (emit_len == '0) ? RD_EMPTY : RD_ISSUE;
                end
            end
            RD_ISSUE:
            begin
                if (out_free)
                begin
                    rd_en      = 1'b1;
                    state_next = RD_LOAD;
                end
            end
            RD_LOAD:
            begin
                load = 1'b1;
                if (is_last)
                begin
                    wb_en      = 1'b1;
                    state_next = RD_ACCEPT;
                end
                else
                begin
                    state_next = RD_ISSUE;
                end
            end
            RD_EMPTY:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    wb_en      = 1'b1;
                    state_next = RD_ACCEPT;
                end
            end
            default:
            begin
                state_next = RD_ACCEPT;
            end
        endcase
    end

    assign accepting = (state_reg == RD_ACCEPT);
    assign rd_addr   = idx_reg;
    assign wb_data   = pend_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= RD_ACCEPT;
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (load)
            begin
                valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
            if (state_reg == RD_ACCEPT)
            begin
                idx_reg <= '0;
            end
            else if (state_reg == RD_LOAD)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == RD_ACCEPT && step.emit)
        begin
            len_reg  <= emit_len;
            pend_reg <= rx_byte;
        end
        if (load)
        begin
            if (state_reg == RD_EMPTY)
            begin
                byte_reg  <= '0;
                last_reg  <= 1'b1;
                empty_reg <= 1'b1;
            end
            else
            begin
                byte_reg  <= rd_data;
                last_reg  <= is_last;
                empty_reg <= 1'b0;
            end
        end
    end

    assign out_valid     = valid_reg;
    assign payload_byte  = byte_reg;
    assign last_of_frame = last_reg;
    assign frame_empty   = empty_reg;

endmodule

>>> design/delimited_frame_receiver.sv
// top level of the delimited frame receiver: marker tracking, frame store, readout
// throughput: one received byte per cycle while no frame is being read out
// frame readout: one ram read, then a load of the result register, per payload byte, or a
//   direct load for an empty frame; it waits while the result register is stalled; input is
//   held off for the whole readout
// first result: registered in the load state after an issue state, or in the empty state
// reset: asynchronous active low; clears phase, open flag, fill index, sequencer, result valid
`include "delimited_frame_receiver_assert.svh"

module delimited_frame_receiver #(
    parameter int STORE_DEPTH = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [dfr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dfr_pkg::BYTE_W-1:0]     cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [dfr_pkg::BYTE_W-1:0]     rx_byte,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [dfr_pkg::BYTE_W-1:0]     payload_byte,
    output logic                           last_of_frame,
    output logic                           frame_empty
);
    import dfr_pkg::*;

    localparam int IDX_W = $clog2(STORE_DEPTH);

    cfg_t              cfg_reg;
    step_t             step;
    logic              take;
    logic              accepting;
    logic [IDX_W-1:0]  store_addr;
    logic [IDX_W-1:0]  emit_len;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic [BYTE_W-1:0] rd_data;
    logic              wb_en;
    logic [BYTE_W-1:0] wb_data;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [BYTE_W-1:0] ram_wdata;

    // configuration registers, to be written only while the block is quiet; the block does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.flag_byte      <= FLAG_RST;
            cfg_reg.start_one_byte <= START_ONE_RST;
            cfg_reg.start_two_byte <= START_TWO_RST;
            cfg_reg.end_one_byte   <= END_ONE_RST;
            cfg_reg.end_two_byte   <= END_TWO_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FLAG:      cfg_reg.flag_byte      <= cfg_data;
                REG_START_ONE: cfg_reg.start_one_byte <= cfg_data;
                REG_START_TWO: cfg_reg.start_two_byte <= cfg_data;
                REG_END_ONE:   cfg_reg.end_one_byte   <= cfg_data;
                REG_END_TWO:   cfg_reg.end_two_byte   <= cfg_data;
                default:       ;
            endcase
        end
    end

    // bytes are taken only while the sequencer is not reading out a frame
    assign in_ready = accepting;
    assign take     = in_valid && in_ready;

    dfr_marker #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_marker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .rx_byte    (rx_byte),
        .take       (take),
        .step       (step),
        .store_addr (store_addr),
        .emit_len   (emit_len)
    );

    dfr_readout #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_readout (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .emit_len      (emit_len),
        .rx_byte       (rx_byte),
        .accepting     (accepting),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data),
        .wb_en         (wb_en),
        .wb_data       (wb_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .payload_byte  (payload_byte),
        .last_of_frame (last_of_frame),
        .frame_empty   (frame_empty)
    );

    // write port: normal byte stores while accepting, the deferred closing byte
    // goes to entry zero once the last payload read has been issued
    assign ram_we    = step.store || wb_en;
    assign ram_waddr = wb_en ? '0 : store_addr;
    assign ram_wdata = wb_en ? wb_data : rx_byte;

    dfr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // readout never overlaps byte intake
    `DFR_ASSERT_IMPLY(a_read_blocks_input, clk, rst_n, rd_en, !in_ready, "read during intake")
    // closing byte write-back reopens intake
    `DFR_ASSERT_NEXT(a_wb_then_accept, clk, rst_n, wb_en, in_ready, "intake not resumed")
    // an empty frame result is always the last one
    `DFR_ASSERT_IMPLY(a_empty_is_last, clk, rst_n, out_valid && frame_empty, last_of_frame,
                      "empty result not last")
    // frame emission immediately stops intake
    `DFR_ASSERT_NEXT(a_emit_stops_input, clk, rst_n, step.emit, !in_ready, "intake after emit")

endmodule
